FILE: rtl/ifp_pkg.sv
`timescale 1ns / 1ps

package ifp_pkg;

  localparam int unsigned StackDepthDefault  = 32;
  localparam int unsigned OperandBitsDefault = 16;
  localparam int unsigned OperandPortBits    = 16;

  typedef enum logic [2:0] {
    TK_OPERAND = 3'd0,
    TK_PLUS    = 3'd1,
    TK_MINUS   = 3'd2,
    TK_MUL     = 3'd3,
    TK_OPEN    = 3'd4,
    TK_CLOSE   = 3'd5,
    TK_END     = 3'd6
  } tok_kind_e;

  typedef enum logic [2:0] {
    OK_OPERAND = 3'd0,
    OK_PLUS    = 3'd1,
    OK_MINUS   = 3'd2,
    OK_MUL     = 3'd3,
    OK_END     = 3'd4
  } out_kind_e;

  typedef enum logic [1:0] {
    SC_PLUS  = 2'd0,
    SC_MINUS = 2'd1,
    SC_MUL   = 2'd2,
    SC_OPEN  = 2'd3
  } stack_code_e;

  typedef enum logic [1:0] {
    ERR_NONE           = 2'd0,
    ERR_UNMATCHED_CLOSE = 2'd1,
    ERR_OVERFLOW       = 2'd2,
    ERR_UNMATCHED_OPEN = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    EM_NONE    = 2'd0,
    EM_OPERAND = 2'd1,
    EM_TOP     = 2'd2,
    EM_END     = 2'd3
  } emit_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DISPATCH = 3'd1,
    ST_READ     = 3'd2,
    ST_CHECK    = 3'd3,
    ST_PUSH     = 3'd4,
    ST_FINISH   = 3'd5
  } state_e;

  typedef struct packed {
    logic        load_tok;
    logic        ram_rd;
    emit_sel_e   emit_sel;
    err_e        err;
    logic        pop;
    logic        push;
    logic        clear;
    logic        open_dec;
    logic        finish;
  } cmd_t;

  typedef struct packed {
    tok_kind_e   kind;
    stack_code_e tok_code;
    stack_code_e top;
    logic        count_zero;
    logic        stack_full;
    logic        open_zero;
    logic        pend_valid;
    logic        out_free;
  } status_t;

  // multiply binds tighter than plus and minus
  function automatic logic prec_of(stack_code_e code);
    return code == SC_MUL;
  endfunction

endpackage

FILE: rtl/infix_to_postfix_converter_top.sv
// An operand result passes through the one-entry holding slot and then the output register;
//   any other result waits in a one-entry slot until the next result is formed or the token finishes.
// A new token is taken only in the idle state, after the previous token has finished; each
//   popped entry needs a stack RAM read, and a full output register can stall any token.
// Reset: asynchronous, active low; empties the stack and drops any pending result.
`timescale 1ns / 1ps

module infix_to_postfix_converter_top #(
  parameter int unsigned STACK_DEPTH  = ifp_pkg::StackDepthDefault,
  parameter int unsigned OPERAND_BITS = ifp_pkg::OperandBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] operand_code
  input  logic [2:0]  s_axis_tuser,  // [2:0] token_kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] out_operand, [17:16] error_code, [23:18] zero
  output logic [2:0]  m_axis_tuser,  // [2:0] out_kind
  output logic        m_axis_tlast   // last_of_run
);

  ifp_pkg::cmd_t    cmd;
  ifp_pkg::status_t status;
  logic [15:0]      out_operand;
  logic [1:0]       error_code;

  ifp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ifp_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .OPERAND_BITS(OPERAND_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_kind_i    (s_axis_tuser),
    .operand_code_i(s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_kind_o    (m_axis_tuser),
    .out_operand_o (out_operand),
    .last_of_run_o (m_axis_tlast),
    .error_code_o  (error_code)
  );

  assign m_axis_tdata = {6'd0, error_code, out_operand};

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !status.stack_full)
    else $error("push onto a full stack");

  a_load_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_tok |-> !status.pend_valid)
    else $error("new token taken while a result is still held");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd.emit_sel != ifp_pkg::EM_NONE || cmd.finish) && status.pend_valid)
      |-> status.out_free)
    else $error("output register overwritten before transfer");

  a_top_emit_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_sel == ifp_pkg::EM_TOP) |-> cmd.pop)
    else $error("top emit without pop");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_sel == ifp_pkg::EM_END) |=> status.count_zero && status.open_zero)
    else $error("end result left entries on the stack");
`endif

endmodule

FILE: rtl/ifp_ram.sv
`timescale 1ns / 1ps

module ifp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ifp_ctrl.sv
`timescale 1ns / 1ps

module ifp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ifp_pkg::status_t status_i,
  output ifp_pkg::cmd_t    cmd_o
);

  ifp_pkg::state_e state_q, state_d;
  logic            gate;
  logic            top_pops;
  logic            is_oper;
  ifp_pkg::err_e   end_err;

  // a new result may enter the holding slot only if the slot can drain
  assign gate     = !status_i.pend_valid || status_i.out_free;
  assign top_pops = (status_i.top != ifp_pkg::SC_OPEN) &&
                    (ifp_pkg::prec_of(status_i.top) >= ifp_pkg::prec_of(status_i.tok_code));
  assign is_oper  = (status_i.kind == ifp_pkg::TK_PLUS) ||
                    (status_i.kind == ifp_pkg::TK_MINUS) ||
                    (status_i.kind == ifp_pkg::TK_MUL);
  assign end_err  = status_i.open_zero ? ifp_pkg::ERR_NONE : ifp_pkg::ERR_UNMATCHED_OPEN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ifp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ifp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ifp_pkg::ST_DISPATCH;
      end
      ifp_pkg::ST_DISPATCH: begin
        unique case (status_i.kind)
          ifp_pkg::TK_OPERAND: state_d = ifp_pkg::ST_FINISH;
          ifp_pkg::TK_PLUS, ifp_pkg::TK_MINUS, ifp_pkg::TK_MUL,
          ifp_pkg::TK_END:     state_d = ifp_pkg::ST_READ;
          ifp_pkg::TK_OPEN:    state_d = ifp_pkg::ST_PUSH;
          ifp_pkg::TK_CLOSE:   state_d = status_i.open_zero ? ifp_pkg::ST_FINISH
                                                            : ifp_pkg::ST_READ;
          default:             state_d = ifp_pkg::ST_IDLE;
        endcase
      end
      ifp_pkg::ST_READ: begin
        if (!status_i.count_zero) begin
          state_d = ifp_pkg::ST_CHECK;
        end else if (is_oper) begin
          state_d = ifp_pkg::ST_PUSH;
        end else if (status_i.kind != ifp_pkg::TK_END || gate) begin
          state_d = ifp_pkg::ST_FINISH;
        end
      end
      ifp_pkg::ST_CHECK: begin
        if (is_oper) begin
          if (!top_pops) state_d = ifp_pkg::ST_PUSH;
          else if (gate) state_d = ifp_pkg::ST_READ;
        end else if (status_i.kind == ifp_pkg::TK_CLOSE &&
                     status_i.top == ifp_pkg::SC_OPEN) begin
          state_d = ifp_pkg::ST_FINISH;
        end else if (status_i.top == ifp_pkg::SC_OPEN || gate) begin
          state_d = ifp_pkg::ST_READ;
        end
      end
      ifp_pkg::ST_PUSH: begin
        if (!status_i.stack_full || gate) state_d = ifp_pkg::ST_FINISH;
      end
      ifp_pkg::ST_FINISH: begin
        if (!status_i.pend_valid || status_i.out_free) state_d = ifp_pkg::ST_IDLE;
      end
      default: state_d = ifp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.emit_sel = ifp_pkg::EM_NONE;
    cmd_o.err      = ifp_pkg::ERR_NONE;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ifp_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_tok = in_valid_i;
      end
      ifp_pkg::ST_DISPATCH: begin
        if (status_i.kind == ifp_pkg::TK_OPERAND) begin
          cmd_o.emit_sel = ifp_pkg::EM_OPERAND;
        end else if (status_i.kind == ifp_pkg::TK_CLOSE && status_i.open_zero) begin
          cmd_o.emit_sel = ifp_pkg::EM_END;
          cmd_o.err      = ifp_pkg::ERR_UNMATCHED_CLOSE;
          cmd_o.clear    = 1'b1;
        end
      end
      ifp_pkg::ST_READ: begin
        if (!status_i.count_zero) begin
          cmd_o.ram_rd = 1'b1;
        end else if (status_i.kind == ifp_pkg::TK_END && gate) begin
          cmd_o.emit_sel = ifp_pkg::EM_END;
          cmd_o.err      = end_err;
          cmd_o.clear    = 1'b1;
        end
      end
      ifp_pkg::ST_CHECK: begin
        if (is_oper) begin
          if (top_pops && gate) begin
            cmd_o.emit_sel = ifp_pkg::EM_TOP;
            cmd_o.pop      = 1'b1;
          end
        end else if (status_i.top == ifp_pkg::SC_OPEN) begin
          // drop the bracket; only a close bracket stops here
          cmd_o.pop      = 1'b1;
          cmd_o.open_dec = status_i.kind == ifp_pkg::TK_CLOSE;
        end else if (gate) begin
          cmd_o.emit_sel = ifp_pkg::EM_TOP;
          cmd_o.pop      = 1'b1;
        end
      end
      ifp_pkg::ST_PUSH: begin
        if (!status_i.stack_full) begin
          cmd_o.push = 1'b1;
        end else if (gate) begin
          cmd_o.emit_sel = ifp_pkg::EM_END;
          cmd_o.err      = ifp_pkg::ERR_OVERFLOW;
          cmd_o.clear    = 1'b1;
        end
      end
      ifp_pkg::ST_FINISH: begin
        cmd_o.finish = status_i.pend_valid && status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/ifp_datapath.sv
`timescale 1ns / 1ps

module ifp_datapath #(
  parameter int unsigned STACK_DEPTH  = ifp_pkg::StackDepthDefault,
  parameter int unsigned OPERAND_BITS = ifp_pkg::OperandBitsDefault
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [2:0]                              tok_kind_i,
  input  logic [ifp_pkg::OperandPortBits-1:0]     operand_code_i,
  input  ifp_pkg::cmd_t                           cmd_i,
  output ifp_pkg::status_t                        status_o,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [2:0]                              out_kind_o,
  output logic [ifp_pkg::OperandPortBits-1:0]     out_operand_o,
  output logic                                    last_of_run_o,
  output logic [1:0]                              error_code_o
);

  localparam int unsigned OpW  = (OPERAND_BITS < ifp_pkg::OperandPortBits) ?
                                 OPERAND_BITS : ifp_pkg::OperandPortBits;
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  ifp_pkg::tok_kind_e kind_q;
  logic [OpW-1:0]     opnd_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    open_q, open_d;
  logic [2:0]         kind_bits;
  ifp_pkg::stack_code_e tok_code;
  ifp_pkg::stack_code_e top;
  logic [1:0]         rdata;

  logic               pend_valid_q, pend_valid_d;
  ifp_pkg::out_kind_e pend_kind_q, new_kind;
  logic [OpW-1:0]     pend_opnd_q, new_opnd;
  ifp_pkg::err_e      pend_err_q, new_err;

  logic               out_valid_q, out_valid_d;
  ifp_pkg::out_kind_e out_kind_q;
  logic [OpW-1:0]     out_opnd_q;
  ifp_pkg::err_e      out_err_q;
  logic               out_last_q;

  logic               emit;
  logic               out_load;
  logic               out_free;

  assign kind_bits = kind_q;
  assign tok_code  = ifp_pkg::stack_code_e'(2'(kind_bits - 3'd1));
  assign top       = ifp_pkg::stack_code_e'(rdata);
  assign emit      = cmd_i.emit_sel != ifp_pkg::EM_NONE;
  assign out_load  = (emit || cmd_i.finish) && pend_valid_q;
  assign out_free  = !out_valid_q || out_ready_i;

  ifp_ram #(
    .WIDTH(2),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i(tok_code),
    .re_i   (cmd_i.ram_rd),
    .raddr_i(IdxW'(count_q - CntW'(1))),
    .rdata_o(rdata)
  );

  always_comb begin
    new_kind = ifp_pkg::OK_END;
    new_opnd = '0;
    new_err  = ifp_pkg::ERR_NONE;
    unique case (cmd_i.emit_sel)
      ifp_pkg::EM_OPERAND: begin
        new_kind = ifp_pkg::OK_OPERAND;
        new_opnd = opnd_q;
      end
      ifp_pkg::EM_TOP: begin
        new_kind = ifp_pkg::out_kind_e'({1'b0, top} + 3'd1);
      end
      ifp_pkg::EM_END: begin
        new_err = cmd_i.err;
      end
      ifp_pkg::EM_NONE: begin
        new_kind = ifp_pkg::OK_END;
      end
      default: begin
        new_kind = ifp_pkg::OK_END;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    open_d  = open_q;
    priority if (cmd_i.clear) begin
      count_d = '0;
      open_d  = '0;
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
      if (cmd_i.open_dec) open_d = open_q - CntW'(1);
    end else if (cmd_i.push) begin
      count_d = count_q + CntW'(1);
      if (tok_code == ifp_pkg::SC_OPEN) open_d = open_q + CntW'(1);
    end
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (emit) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.finish) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      open_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      open_q       <= open_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      kind_q <= ifp_pkg::tok_kind_e'(tok_kind_i);
      opnd_q <= operand_code_i[OpW-1:0];
    end
    if (emit) begin
      pend_kind_q <= new_kind;
      pend_opnd_q <= new_opnd;
      pend_err_q  <= new_err;
    end
    if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_opnd_q <= pend_opnd_q;
      out_err_q  <= pend_err_q;
      out_last_q <= cmd_i.finish;
    end
  end

  assign status_o.kind       = kind_q;
  assign status_o.tok_code   = tok_code;
  assign status_o.top        = top;
  assign status_o.count_zero = count_q == '0;
  assign status_o.stack_full = count_q >= CntW'(STACK_DEPTH);
  assign status_o.open_zero  = open_q == '0;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_operand_o = ifp_pkg::OperandPortBits'(out_opnd_q);
  assign last_of_run_o = out_last_q;
  assign error_code_o  = out_err_q;

endmodule
